/* design/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// Bracket balance completer package
// Shared types, constants and character decode functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 32;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   // Function codes on the request channel
   localparam logic [1:0] FUNC_APPEND   = 2'd0;
   localparam logic [1:0] FUNC_COMPLETE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR    = 2'd2;

   // Closer codes held in the stack
   localparam logic [1:0] CODE_BRACE   = 2'd0;
   localparam logic [1:0] CODE_BRACKET = 2'd1;
   localparam logic [1:0] CODE_PAREN   = 2'd2;
   localparam logic [1:0] CODE_ANGLE   = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] closer;
      logic       has_closer;
      logic       last_closer;
      logic       syntax_error;
      logic       overflow;
   } rsp_type;

   // Stack move applied to every cell at once
   typedef enum logic [1:0] {
      STK_HOLD = 2'd0,
      STK_PUSH = 2'd1,
      STK_POP  = 2'd2
   } stk_op_type;

   typedef struct packed {
      stk_op_type op;
      logic       load_shadow;
      logic       shift_shadow;
   } cell_ctrl_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] code;
   } decode_type;

   function automatic decode_type opener_decode(input logic [7:0] b);
      decode_type d;
      d.hit  = 1'b1;
      d.code = CODE_BRACE;
      case (b)
         8'h7B:   d.code = CODE_BRACE;    // {
         8'h5B:   d.code = CODE_BRACKET;  // [
         8'h28:   d.code = CODE_PAREN;    // (
         8'h3C:   d.code = CODE_ANGLE;    // <
         default: d.hit  = 1'b0;
      endcase
      return d;
   endfunction

   function automatic decode_type closer_decode(input logic [7:0] b);
      decode_type d;
      d.hit  = 1'b1;
      d.code = CODE_BRACE;
      case (b)
         8'h7D:   d.code = CODE_BRACE;    // }
         8'h5D:   d.code = CODE_BRACKET;  // ]
         8'h29:   d.code = CODE_PAREN;    // )
         8'h3E:   d.code = CODE_ANGLE;    // >
         default: d.hit  = 1'b0;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] closer_ascii(input logic [1:0] code);
      logic [7:0] c;
      case (code)
         CODE_BRACE:   c = 8'h7D;
         CODE_BRACKET: c = 8'h5D;
         CODE_PAREN:   c = 8'h29;
         CODE_ANGLE:   c = 8'h3E;
         default:      c = 8'h7D;
      endcase
      return c;
   endfunction

endpackage

/* design/bbc_cell.sv */
// ----------------------------------------------------------------------------
// Bracket stack cell
// One stack entry plus one shadow entry used to stream out a completion run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_cell
   import bbc_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic [1:0]    from_above,   // neighbor toward the top (push)
   input  logic [1:0]    from_below,   // neighbor toward the bottom (pop)
   input  logic [1:0]    shadow_below, // shadow shifts toward the top
   output logic [1:0]    stk_val,
   output logic [1:0]    shadow_val
);

   logic [1:0] stk_ff, stk_in;
   logic [1:0] shadow_ff, shadow_in;

   // Stack entry moves with push and pop
   always_comb begin
      case (ctrl.op)
         STK_PUSH: stk_in = from_above;
         STK_POP:  stk_in = from_below;
         default:  stk_in = stk_ff;
      endcase
   end

   // Shadow copy for completion readout
   always_comb begin
      if (ctrl.load_shadow) begin
         shadow_in = stk_ff;
      end else if (ctrl.shift_shadow) begin
         shadow_in = shadow_below;
      end else begin
         shadow_in = shadow_ff;
      end
   end

   always_ff @(posedge clock) begin
      stk_ff    <= stk_in;
      shadow_ff <= shadow_in;
   end

   assign stk_val    = stk_ff;
   assign shadow_val = shadow_ff;

endmodule

/* design/bracket_balance_completer_core.sv */
// ----------------------------------------------------------------------------
// Bracket balance completer core
// Tracks bracket nesting in a byte stream and lists the pending closers.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data) carries one command per
//   transfer: append a byte, request completion, or clear. rsp channel
//   (rsp_valid / rsp_stall / rsp_data) carries completion results.
//   The stack is a row of cells with the top in cell 0; a push or pop moves
//   every cell at once, so an append or clear never stalls the request
//   channel and the next command can be taken in the following cycle.
//   A completion copies the stack into the shadow row of the cells and
//   shifts it out one closer per cycle while the receiver does not stall:
//   n results (one if the stack is empty), each registered in the output
//   register in the drain state. req_stall is high while the run drains,
//   so no command is taken until the last result is registered.
//   A result waits in the output register while rsp_stall is high; appends
//   and clears are still taken during that time.
//   Reset empties the stack and drops both flags and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_completer_core
   import bbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [RES_W-1:0] remain_ff, remain_in;
   logic             err_ff, err_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_ctrl_type    ctrl;
   logic [1:0]       push_code;
   logic [1:0]       stk_val    [STACK_DEPTH];
   logic [1:0]       shadow_val [STACK_DEPTH];

   logic             take;
   logic             out_free;
   logic             emit;
   decode_type       op_dec;
   decode_type       cl_dec;

   assign req_stall = (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (state_ff == ST_DRAIN) && out_free;
   assign op_dec    = opener_decode(req_data.in_byte);
   assign cl_dec    = closer_decode(req_data.in_byte);
   assign push_code = op_dec.code;

   // Command decode, stack moves and flags
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      remain_in         = remain_ff;
      err_in            = err_ff;
      ovf_in            = ovf_ff;
      ctrl.op           = STK_HOLD;
      ctrl.load_shadow  = 1'b0;
      ctrl.shift_shadow = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               case (req_data.func)
                  FUNC_APPEND: begin
                     if (!err_ff && !ovf_ff) begin
                        if (op_dec.hit) begin
                           if (count_ff == CNT_W'(STACK_DEPTH)) begin
                              ovf_in = 1'b1;
                           end else begin
                              ctrl.op  = STK_PUSH;
                              count_in = count_ff + CNT_W'(1);
                           end
                        end else if (cl_dec.hit) begin
                           if (count_ff != '0 && stk_val[0] == cl_dec.code) begin
                              ctrl.op  = STK_POP;
                              count_in = count_ff - CNT_W'(1);
                           end else begin
                              err_in = 1'b1;
                           end
                        end
                     end
                  end
                  FUNC_COMPLETE: begin
                     ctrl.load_shadow = 1'b1;
                     state_in         = ST_DRAIN;
                     if (int'(count_ff) > MAX_RESULTS) begin
                        remain_in = RES_W'(MAX_RESULTS);
                     end else begin
                        remain_in = RES_W'(count_ff);
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                     err_in   = 1'b0;
                     ovf_in   = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               ctrl.shift_shadow = 1'b1;
               if (remain_ff <= RES_W'(1)) begin
                  state_in  = ST_IDLE;
                  remain_in = '0;
               end else begin
                  remain_in = remain_ff - RES_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_in.has_closer   = (remain_ff != '0);
         rsp_in.closer       = (remain_ff != '0) ? closer_ascii(shadow_val[0]) : 8'h00;
         rsp_in.last_closer  = (remain_ff <= RES_W'(1));
         rsp_in.syntax_error = err_ff;
         rsp_in.overflow     = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         err_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         err_ff       <= err_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Row of stack cells, top at index 0
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [1:0] above;
      logic [1:0] below;
      logic [1:0] sh_below;
      if (i == 0) begin : g_top
         assign above = push_code;
      end else begin : g_mid
         assign above = stk_val[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign below    = 2'b00;
         assign sh_below = 2'b00;
      end else begin : g_up
         assign below    = stk_val[i+1];
         assign sh_below = shadow_val[i+1];
      end
      bbc_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .from_above   (above),
         .from_below   (below),
         .shadow_below (sh_below),
         .stk_val      (stk_val[i]),
         .shadow_val   (shadow_val[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/bracket_balance_completer_core_tb.sv */
// ----------------------------------------------------------------------------
// Bracket balance completer core testbench
// Drives append, completion and clear commands with random gaps on both
// channels and checks every completion result against a cycle-free
// predictor of the closer stack and its sticky flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_completer_core_tb;
   import bbc_pkg::*;

   // Command value with no defined function
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int ITEM_TARGET     = 300;
   localparam int PRESSURE_AT     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 1200000;
   localparam int TAIL_CYCLES     = 20;
   localparam int REPORT_CAP      = 40;

   // -------------------------------------------------------------------------
   // Predictor and checker of completion results
   // -------------------------------------------------------------------------
   class closer_list_checker;
      logic [1:0]  stack_codes [STACK_DEPTH];
      int unsigned depth;
      bit          err_flag;
      bit          ovf_flag;
      rsp_type     awaited_results [$];
      int          errors;

      function new();
         depth    = 0;
         err_flag = 1'b0;
         ovf_flag = 1'b0;
         errors   = 0;
      endfunction

      static function logic [7:0] open_char(logic [1:0] code);
         case (code)
            CODE_BRACE:   return 8'h7B;  // {
            CODE_BRACKET: return 8'h5B;  // [
            CODE_PAREN:   return 8'h28;  // (
            default:      return 8'h3C;  // <
         endcase
      endfunction

      static function logic [7:0] close_char(logic [1:0] code);
         case (code)
            CODE_BRACE:   return 8'h7D;  // }
            CODE_BRACKET: return 8'h5D;  // ]
            CODE_PAREN:   return 8'h29;  // )
            default:      return 8'h3E;  // >
         endcase
      endfunction

      // -1 when the byte is not an opener
      static function int open_code(logic [7:0] b);
         for (int k = 0; k < 4; k++)
            if (b == open_char(k[1:0])) return k;
         return -1;
      endfunction

      // -1 when the byte is not a closer
      static function int close_code(logic [7:0] b);
         for (int k = 0; k < 4; k++)
            if (b == close_char(k[1:0])) return k;
         return -1;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // Advance the stack for one accepted command, queue its results
      function void note_request(req_type r);
         int          oc;
         int          cc;
         int unsigned n;
         rsp_type     res;
         case (r.func)
            FUNC_APPEND: begin
               if (!err_flag && !ovf_flag) begin
                  oc = open_code(r.in_byte);
                  cc = close_code(r.in_byte);
                  if (oc >= 0) begin
                     if (depth >= STACK_DEPTH) begin
                        ovf_flag = 1'b1;
                     end else begin
                        stack_codes[depth] = oc[1:0];
                        depth++;
                     end
                  end else if (cc >= 0) begin
                     if (depth > 0 && stack_codes[depth-1] == cc[1:0])
                        depth--;
                     else
                        err_flag = 1'b1;
                  end
               end
            end
            FUNC_COMPLETE: begin
               res.syntax_error = err_flag;
               res.overflow     = ovf_flag;
               if (depth == 0) begin
                  // empty stack: a single marker result with no closer
                  res.closer      = 8'h00;
                  res.has_closer  = 1'b0;
                  res.last_closer = 1'b1;
                  awaited_results.insert(awaited_results.size(), res);
               end else begin
                  n = (depth > MAX_RESULTS) ? MAX_RESULTS : depth;
                  for (int unsigned k = 0; k < n; k++) begin
                     res.closer      = close_char(stack_codes[depth-1-k]);
                     res.has_closer  = 1'b1;
                     res.last_closer = (k + 1 == n);
                     awaited_results.insert(awaited_results.size(), res);
                  end
               end
            end
            FUNC_CLEAR: begin
               depth    = 0;
               err_flag = 1'b0;
               ovf_flag = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
         if (got_v !== exp_v) begin
            if (errors < REPORT_CAP)
               $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
            errors++;
         end
      endfunction

      // Compare one accepted result with the oldest awaited one
      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            if (errors < REPORT_CAP)
               $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("closer", want.closer, got.closer);
         compare_field("has_closer", 8'(want.has_closer), 8'(got.has_closer));
         compare_field("last_closer", 8'(want.last_closer), 8'(got.last_closer));
         compare_field("syntax_error", 8'(want.syntax_error), 8'(got.syntax_error));
         compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block
   // -------------------------------------------------------------------------
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   closer_list_checker sb = new();

   int cycle_count = 0;
   int item_count  = 0;
   bit no_gaps       = 1'b0;
   bit hold_off_req  = 1'b0;
   bit pressure_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bracket_balance_completer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Note every transfer on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall segments, plus one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int pick;
      int len;
      bit level;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            level        = 1'b1;
            len          = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               level = 1'b0;
               len   = $urandom_range(5, 40);
            end else if (pick < 85) begin
               level = 1'b1;
               len   = $urandom_range(1, 3);
            end else begin
               level = 1'b1;
               len   = $urandom_range(8, 25);
            end
         end
         rsp_stall <= level;
         repeat (len) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Byte that is neither an opener nor a closer
   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (closer_list_checker::open_code(b) >= 0 || closer_list_checker::close_code(b) >= 0)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // One transfer on the request channel
   task automatic send(logic [1:0] f, logic [7:0] b);
      req_type item;
      int      gap;
      item.func    = f;
      item.in_byte = b;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
   endtask

   task automatic send_open(logic [1:0] code);
      send(FUNC_APPEND, closer_list_checker::open_char(code));
   endtask

   task automatic send_close(logic [1:0] code);
      send(FUNC_APPEND, closer_list_checker::close_char(code));
   endtask

   // Stop offering and wait for every awaited result
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Nested text that closes itself, with filler and completions inside;
   // now and then it breaks with a wrong closer and gets cleared
   task automatic run_phrase();
      logic [1:0] opened [$];
      logic [1:0] c;
      int         target;
      int         broken_at;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 70)      target = $urandom_range(1, 6);
      else if (r < 92) target = $urandom_range(7, 20);
      else             target = $urandom_range(21, STACK_DEPTH);
      no_gaps   = ($urandom_range(0, 3) == 0);
      broken_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, target) : -1;
      for (int i = 0; i < target; i++) begin
         if ($urandom_range(0, 4) == 0) send(FUNC_APPEND, filler_byte());
         c = 2'($urandom_range(0, 3));
         send_open(c);
         opened.insert(opened.size(), c);
         if ($urandom_range(0, 9) == 0) send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      end
      for (int k = 0; k <= target; k++) begin
         if (k == broken_at) begin
            // mismatched closer, or a closer on an empty stack
            if (opened.size() == 0) c = 2'($urandom_range(0, 3));
            else c = opened[$] + 2'($urandom_range(1, 3));
            send_close(c);
            repeat ($urandom_range(1, 4)) send(FUNC_APPEND, 8'($urandom_range(0, 255)));
            send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
            send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
            return;
         end
         if (k == target) break;
         if ($urandom_range(0, 4) == 0) send(FUNC_APPEND, filler_byte());
         send_close(opened.pop_back());
         if ($urandom_range(0, 9) == 0) send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 1) == 0) send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0) send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
   endtask

   // Arbitrary commands, then a clear to get back to a known stack
   task automatic run_noise();
      no_gaps = 1'b0;
      repeat ($urandom_range(3, 8))
         send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
   endtask

   // Full stack under a long receiver hold-off, then overflow
   task automatic run_pressure();
      hold_off_req = 1'b1;
      no_gaps      = 1'b1;
      send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
      repeat (STACK_DEPTH) send_open(2'($urandom_range(0, 3)));
      repeat (3) send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      send_open(2'($urandom_range(0, 3)));
      send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      repeat (3) send(FUNC_APPEND, 8'($urandom_range(0, 255)));
      send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      send(FUNC_CLEAR, 8'($urandom_range(0, 255)));
      send(FUNC_COMPLETE, 8'($urandom_range(0, 255)));
      wait_drained();
      pressure_done = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty completion, byte extremes, unused function,
      // every opener and closer, closer on empty, mismatched closer
      send(FUNC_COMPLETE, 8'h00);
      send(FUNC_APPEND, 8'h00);
      send(FUNC_APPEND, 8'hFF);
      send(FUNC_UNUSED, 8'hFF);
      send_open(CODE_BRACE);
      send_open(CODE_BRACKET);
      send_open(CODE_PAREN);
      send_open(CODE_ANGLE);
      send(FUNC_COMPLETE, 8'hFF);
      send_close(CODE_ANGLE);
      send_close(CODE_PAREN);
      send_close(CODE_BRACKET);
      send_close(CODE_BRACE);
      send(FUNC_COMPLETE, 8'h00);
      send_close(CODE_PAREN);
      send_open(CODE_PAREN);
      send(FUNC_COMPLETE, 8'h00);
      send(FUNC_CLEAR, 8'hFF);
      send_open(CODE_BRACKET);
      send_close(CODE_BRACE);
      send(FUNC_COMPLETE, 8'h00);
      send(FUNC_CLEAR, 8'h00);
      send(FUNC_COMPLETE, 8'h00);
      wait_drained();

      // Random phrases
      while (item_count < ITEM_TARGET) begin
         if (item_count >= PRESSURE_AT && !pressure_done) run_pressure();
         else if ($urandom_range(0, 9) == 0) run_noise();
         else run_phrase();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
